@@ sv/sha1md_pkg.sv @@
// shared types, constants and round helpers of the sha-1 digest block
package sha1md_pkg;

  localparam int          ROUNDS      = 80;
  localparam int          WIN_WORDS   = 16;
  localparam int          CHAIN_WORDS = 5;
  localparam logic [6:0]  BLOCK_BYTES = 7'd64;
  localparam logic [5:0]  LEN_OFFSET  = 6'd56;
  localparam logic [2:0]  MAX_BYTES   = 3'd4;
  localparam logic [31:0] PAD_MARK    = 32'h8000_0000;

  localparam logic [31:0] INIT_CHAIN [CHAIN_WORDS] = '{
    32'h6745_2301, 32'hefcd_ab89, 32'h98ba_dcfe, 32'h1032_5476, 32'hc3d2_e1f0
  };

  localparam logic [31:0] K_ROUND_0 = 32'h5a82_7999;
  localparam logic [31:0] K_ROUND_1 = 32'h6ed9_eba1;
  localparam logic [31:0] K_ROUND_2 = 32'h8f1b_bcdc;
  localparam logic [31:0] K_ROUND_3 = 32'hca62_c1d6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ABSORB,
    ST_ROUND,
    ST_FOLD,
    ST_PAD_FIRST,
    ST_PAD_SECOND,
    ST_EMIT
  } ctrl_state_t;

  typedef enum logic [1:0] {
    PH_MESSAGE,
    PH_SPILL,
    PH_FINAL
  } phase_t;

  typedef struct packed {
    logic absorb_in;
    logic absorb_hold;
    logic pad_first;
    logic pad_second;
    logic start_rounds;
    logic do_round;
    logic fold;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic block_full;
    logic hold_empty;
    logic hold_last;
    logic in_last;
    logic pad_spill;
    logic round_last;
    logic out_free;
  } dp_status_t;

  function automatic logic [31:0] round_const(input logic [6:0] t);
    logic [31:0] k;
    if (t < 7'd20) k = K_ROUND_0;
    else if (t < 7'd40) k = K_ROUND_1;
    else if (t < 7'd60) k = K_ROUND_2;
    else k = K_ROUND_3;
    return k;
  endfunction

  function automatic logic [31:0] round_func(input logic [6:0] t, input logic [31:0] b,
                                             input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (t < 7'd20) f = (b & c) ^ (~b & d);
    else if (t < 7'd40) f = b ^ c ^ d;
    else if (t < 7'd60) f = (b & c) ^ (b & d) ^ (c & d);
    else f = b ^ c ^ d;
    return f;
  endfunction

endpackage

@@ sv/sha1md_in_if.sv @@
// message word channel
interface sha1md_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  bytes_valid;
  logic        last_item;

  modport source (output valid, output data_word, output bytes_valid, output last_item,
                  input ready);
  modport sink (input valid, input data_word, input bytes_valid, input last_item,
                output ready);
endinterface

@@ sv/sha1md_out_if.sv @@
// digest result channel
interface sha1md_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_top;
  logic [63:0] digest_middle;
  logic [31:0] digest_bottom;

  modport source (output valid, output digest_top, output digest_middle,
                  output digest_bottom, input ready);
  modport sink (input valid, input digest_top, input digest_middle, input digest_bottom,
                output ready);
endinterface

@@ sv/sha1md_dp.sv @@
// datapath: block window, byte packing, padding, round unit and digest register
module sha1md_dp import sha1md_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  output dp_status_t  status,
  input  logic [31:0] data_word,
  input  logic [2:0]  bytes_valid,
  input  logic        last_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] digest_top,
  output logic [63:0] digest_middle,
  output logic [31:0] digest_bottom
);

  logic [31:0] chain [CHAIN_WORDS];
  logic [31:0] work [CHAIN_WORDS];
  logic [31:0] win [WIN_WORDS];
  logic [31:0] win_next [WIN_WORDS];
  logic [6:0]  round_index;
  logic [5:0]  block_fill;
  logic [63:0] message_bits;
  logic [31:0] hold_word;
  logic [2:0]  hold_count;
  logic        hold_last;

  logic [2:0]  in_count;
  logic [31:0] src_word;
  logic [2:0]  src_count;
  logic [6:0]  fill_sum;
  logic [6:0]  room;
  logic [2:0]  take;
  logic [6:0]  fill_after;
  logic        pad_spill;
  logic        write_en;
  logic        zero_en;
  logic        len_write;
  logic [31:0] sched_new;
  logic [31:0] round_sum;

  assign in_count = (bytes_valid > MAX_BYTES) ? MAX_BYTES : bytes_valid;

  always_comb begin
    priority if (cmd.absorb_hold) begin
      src_word  = hold_word;
      src_count = hold_count;
    end else if (cmd.pad_first) begin
      src_word  = PAD_MARK;
      src_count = 3'd1;
    end else if (cmd.pad_second) begin
      src_word  = '0;
      src_count = 3'd0;
    end else begin
      src_word  = data_word;
      src_count = in_count;
    end
  end

  // bytes that still fit in the current block
  assign fill_sum   = {1'b0, block_fill} + {4'b0, src_count};
  assign room       = BLOCK_BYTES - {1'b0, block_fill};
  assign take       = (fill_sum > BLOCK_BYTES) ? room[2:0] : src_count;
  assign fill_after = {1'b0, block_fill} + {4'b0, take};
  assign pad_spill  = block_fill >= LEN_OFFSET;

  assign write_en  = cmd.absorb_in | cmd.absorb_hold | cmd.pad_first | cmd.pad_second;
  assign zero_en   = cmd.pad_first | cmd.pad_second;
  assign len_write = cmd.pad_second | (cmd.pad_first & ~pad_spill);

  assign sched_new = {win[13][30:0] ^ win[8][30:0] ^ win[2][30:0] ^ win[0][30:0],
                      win[13][31] ^ win[8][31] ^ win[2][31] ^ win[0][31]};

  always_comb begin
    logic [5:0] pos;
    logic [5:0] byte_ofs;
    pos      = '0;
    byte_ofs = '0;
    win_next = win;
    if (cmd.do_round) begin
      for (int i = 0; i < WIN_WORDS - 1; i++) win_next[i] = win[i + 1];
      win_next[WIN_WORDS - 1] = sched_new;
    end else if (write_en) begin
      for (int p = 0; p < 64; p++) begin
        pos      = 6'(p);
        byte_ofs = pos - block_fill;
        if (pos >= block_fill && byte_ofs < {3'b0, take}) begin
          win_next[p >> 2][8 * (3 - (p & 3)) +: 8] = src_word[8 * (3 - byte_ofs[1:0]) +: 8];
        end else if (zero_en && pos >= block_fill) begin
          win_next[p >> 2][8 * (3 - (p & 3)) +: 8] = 8'h00;
        end
      end
      // bit length goes in the last two words of the block
      if (len_write) begin
        win_next[WIN_WORDS - 2] = message_bits[63:32];
        win_next[WIN_WORDS - 1] = message_bits[31:0];
      end
    end
  end

  assign round_sum = {work[0][26:0], work[0][31:27]}
                   + round_func(round_index, work[1], work[2], work[3])
                   + work[4] + round_const(round_index) + win[0];

  always_ff @(posedge clk) begin
    win <= win_next;
    if (cmd.start_rounds) begin
      for (int i = 0; i < CHAIN_WORDS; i++) work[i] <= chain[i];
    end else if (cmd.do_round) begin
      work[0] <= round_sum;
      work[1] <= work[0];
      work[2] <= {work[1][1:0], work[1][31:2]};
      work[3] <= work[2];
      work[4] <= work[3];
    end
    if (cmd.absorb_in || cmd.absorb_hold) begin
      hold_word <= src_word << {take, 3'b000};
    end
    if (cmd.emit) begin
      digest_top    <= {chain[0], chain[1]};
      digest_middle <= {chain[2], chain[3]};
      digest_bottom <= chain[4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHAIN_WORDS; i++) chain[i] <= INIT_CHAIN[i];
      round_index  <= '0;
      block_fill   <= '0;
      message_bits <= '0;
      hold_count   <= '0;
      hold_last    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.start_rounds) round_index <= '0;
      else if (cmd.do_round) round_index <= round_index + 7'd1;

      if (cmd.fold) begin
        for (int i = 0; i < CHAIN_WORDS; i++) chain[i] <= chain[i] + work[i];
      end

      if (cmd.absorb_in || cmd.absorb_hold) begin
        block_fill <= fill_after[5:0];
        hold_count <= src_count - take;
      end else if (cmd.pad_first) begin
        block_fill <= '0;
      end

      if (cmd.absorb_in) begin
        message_bits <= message_bits + {58'b0, in_count, 3'b000};
        hold_last    <= last_item;
      end

      if (cmd.emit) begin
        for (int i = 0; i < CHAIN_WORDS; i++) chain[i] <= INIT_CHAIN[i];
        block_fill   <= '0;
        message_bits <= '0;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    status.block_full = fill_after == BLOCK_BYTES;
    status.hold_empty = hold_count == 3'd0;
    status.hold_last  = hold_last;
    status.in_last    = last_item;
    status.pad_spill  = pad_spill;
    status.round_last = round_index == 7'(ROUNDS - 1);
    status.out_free   = ~out_valid | out_ready;
  end

endmodule

@@ sv/sha1md_ctrl.sv @@
// controller: sequences word packing, compression rounds, padding and digest output
module sha1md_ctrl import sha1md_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state, state_next;
  phase_t      phase, phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= PH_MESSAGE;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.absorb_in = 1'b1;
          if (status.block_full) begin
            cmd.start_rounds = 1'b1;
            phase_next       = PH_MESSAGE;
            state_next       = ST_ROUND;
          end else if (status.in_last) begin
            state_next = ST_PAD_FIRST;
          end
        end
      end
      ST_ABSORB: begin
        cmd.absorb_hold = 1'b1;
        if (status.block_full) begin
          cmd.start_rounds = 1'b1;
          phase_next       = PH_MESSAGE;
          state_next       = ST_ROUND;
        end else if (status.hold_last) begin
          state_next = ST_PAD_FIRST;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_ROUND: begin
        cmd.do_round = 1'b1;
        if (status.round_last) state_next = ST_FOLD;
      end
      ST_FOLD: begin
        cmd.fold = 1'b1;
        unique case (phase)
          PH_MESSAGE: begin
            // leftover bytes of a word that crossed the block boundary
            if (!status.hold_empty) state_next = ST_ABSORB;
            else if (status.hold_last) state_next = ST_PAD_FIRST;
            else state_next = ST_IDLE;
          end
          PH_SPILL: state_next = ST_PAD_SECOND;
          PH_FINAL: state_next = ST_EMIT;
          default:  state_next = ST_IDLE;
        endcase
      end
      ST_PAD_FIRST: begin
        cmd.pad_first    = 1'b1;
        cmd.start_rounds = 1'b1;
        phase_next       = status.pad_spill ? PH_SPILL : PH_FINAL;
        state_next       = ST_ROUND;
      end
      ST_PAD_SECOND: begin
        cmd.pad_second   = 1'b1;
        cmd.start_rounds = 1'b1;
        phase_next       = PH_FINAL;
        state_next       = ST_ROUND;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ sv/sha1_message_digest.sv @@
// sha-1 message digest: packs big-endian words into 64-byte blocks, pads, emits 160-bit digest
// one word per cycle while a block fills; a full block then runs 80 rounds through the
// single round unit plus one chaining add, and no word is taken while they run
// after the last word one more block is compressed before the digest is valid, or two when
// the last word closes a block or the length needs a second padding block
// the digest sits in an output register, so the next message streams in while it waits
// synchronous reset restores the initial chaining words and clears length and fill
module sha1_message_digest import sha1md_pkg::*; (
  input logic           clk,
  input logic           rst,
  sha1md_in_if.sink     in_ch,
  sha1md_out_if.source  out_ch
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;

  assign in_ch.ready = in_ready;

  sha1md_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  sha1md_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .data_word     (in_ch.data_word),
    .bytes_valid   (in_ch.bytes_valid),
    .last_item     (in_ch.last_item),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .digest_top    (out_ch.digest_top),
    .digest_middle (out_ch.digest_middle),
    .digest_bottom (out_ch.digest_bottom)
  );

endmodule
